>>> design/assert_macros.svh
// Assertion helpers shared by the RTL; clock and active-low reset are passed in.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

// Condition that must never hold.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

>>> design/trm_pkg.sv
package trm_pkg;

    localparam int NUM_REGS  = 8;
    localparam int MEM_WORDS = 64;
    localparam int MAX_LINES = 256;

    localparam int DATA_W = 32;
    localparam int VAL_W  = 31;
    localparam int REG_AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int MEM_AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int LINE_W = $clog2(MAX_LINES);

    // operation codes
    localparam logic [2:0] OP_MOV = 3'd0;
    localparam logic [2:0] OP_PRN = 3'd1;
    localparam logic [2:0] OP_SUB = 3'd2;
    localparam logic [2:0] OP_ADD = 3'd3;
    localparam logic [2:0] OP_JMP = 3'd4;
    localparam logic [2:0] OP_JPN = 3'd5;
    localparam logic [2:0] OP_HLT = 3'd6;

    // operand kinds
    localparam logic [1:0] KIND_CONST = 2'd0;
    localparam logic [1:0] KIND_REG   = 2'd1;
    localparam logic [1:0] KIND_MEM   = 2'd2;

    // fault codes
    localparam logic [2:0] FAULT_OK         = 3'd0;
    localparam logic [2:0] FAULT_BAD_REG    = 3'd1;
    localparam logic [2:0] FAULT_BAD_ADDR   = 3'd2;
    localparam logic [2:0] FAULT_BAD_TARGET = 3'd3;
    localparam logic [2:0] FAULT_ILLEGAL    = 3'd4;
    localparam logic [2:0] FAULT_UNKNOWN    = 3'd5;

    // line counter update selection
    localparam logic [2:0] LS_HOLD       = 3'd0;
    localparam logic [2:0] LS_ADV        = 3'd1;
    localparam logic [2:0] LS_JUMP_FIRST = 3'd2;
    localparam logic [2:0] LS_IF_ZERO    = 3'd3;
    localparam logic [2:0] LS_IF_NONPOS  = 3'd4;

    // register write data selection
    localparam logic [1:0] RS_VAL1   = 2'd0;
    localparam logic [1:0] RS_CONST2 = 2'd1;
    localparam logic [1:0] RS_ADD    = 2'd2;
    localparam logic [1:0] RS_SUB    = 2'd3;

    typedef struct packed {
        logic [2:0]       op;
        logic [1:0]       first_kind;
        logic [VAL_W-1:0] first_value;
        logic [1:0]       second_kind;
        logic [VAL_W-1:0] second_value;
    } insn_t;

    typedef struct packed {
        logic [2:0] fault;
        logic [2:0] line_sel;
        logic       print;
        logic       halt;
        logic       reg_we;
        logic       reg_dst_first;
        logic [1:0] reg_src;
        logic       mem_we;
        logic       mem_dst_first;
        logic       mem_src_const;
    } ctrl_t;

endpackage

>>> design/trm_ram.sv
module trm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/trm_decode.sv
module trm_decode
    import trm_pkg::*;
(
    input  insn_t insn,
    output ctrl_t ctrl
);

    logic       k1c, k1r, k1m, k2c, k2r, k2m;
    logic       reg_ok1, reg_ok2, mem_ok1, mem_ok2, tgt_ok1, tgt_ok2;
    logic [2:0] opf1, opf2;

    always_comb
    begin
        k1c = (insn.first_kind == KIND_CONST);
        k1r = (insn.first_kind == KIND_REG);
        k1m = (insn.first_kind == KIND_MEM);
        k2c = (insn.second_kind == KIND_CONST);
        k2r = (insn.second_kind == KIND_REG);
        k2m = (insn.second_kind == KIND_MEM);

        reg_ok1 = (insn.first_value != '0) && (insn.first_value <= VAL_W'(NUM_REGS));
        reg_ok2 = (insn.second_value != '0) && (insn.second_value <= VAL_W'(NUM_REGS));
        mem_ok1 = (insn.first_value < VAL_W'(MEM_WORDS));
        mem_ok2 = (insn.second_value < VAL_W'(MEM_WORDS));
        tgt_ok1 = (insn.first_value != '0) && (insn.first_value <= VAL_W'(MAX_LINES));
        tgt_ok2 = (insn.second_value != '0) && (insn.second_value <= VAL_W'(MAX_LINES));

        opf1 = (k1r && !reg_ok1) ? FAULT_BAD_REG :
               ((k1m && !mem_ok1) ? FAULT_BAD_ADDR : FAULT_OK);
        opf2 = (k2r && !reg_ok2) ? FAULT_BAD_REG :
               ((k2m && !mem_ok2) ? FAULT_BAD_ADDR : FAULT_OK);
    end

    always_comb
    begin
        ctrl = '0;
        case (insn.op)
            OP_MOV:
            begin
                ctrl.line_sel = LS_ADV;
                if (!((k1r && (k2c || k2r || k2m)) || (k1m && (k2r || k2c))))
                begin
                    ctrl.fault = FAULT_ILLEGAL;
                end
                else
                begin
                    ctrl.fault = (opf1 != FAULT_OK) ? opf1 : opf2;
                end
                if (k2m)
                begin
                    ctrl.mem_we = 1'b1;
                end
                else if (k2r)
                begin
                    ctrl.reg_we  = 1'b1;
                    ctrl.reg_src = RS_VAL1;
                end
                else if (k1r)
                begin
                    ctrl.reg_we        = 1'b1;
                    ctrl.reg_dst_first = 1'b1;
                    ctrl.reg_src       = RS_CONST2;
                end
                else
                begin
                    ctrl.mem_we        = 1'b1;
                    ctrl.mem_dst_first = 1'b1;
                    ctrl.mem_src_const = 1'b1;
                end
            end
            OP_PRN:
            begin
                ctrl.line_sel = LS_ADV;
                ctrl.print    = 1'b1;
                ctrl.fault    = (k1c || k1r || k1m) ? opf1 : FAULT_ILLEGAL;
            end
            OP_SUB, OP_ADD:
            begin
                ctrl.line_sel      = LS_ADV;
                ctrl.reg_we        = 1'b1;
                ctrl.reg_dst_first = 1'b1;
                ctrl.reg_src       = (insn.op == OP_ADD) ? RS_ADD : RS_SUB;
                if (!(k1r && (k2c || k2r || k2m)))
                begin
                    ctrl.fault = FAULT_ILLEGAL;
                end
                else
                begin
                    ctrl.fault = (opf1 != FAULT_OK) ? opf1 : opf2;
                end
            end
            OP_JMP, OP_JPN:
            begin
                if (insn.op == OP_JMP && k1c)
                begin
                    ctrl.line_sel = LS_JUMP_FIRST;
                    ctrl.fault    = tgt_ok1 ? FAULT_OK : FAULT_BAD_TARGET;
                end
                else
                begin
                    ctrl.line_sel = (insn.op == OP_JMP) ? LS_IF_ZERO : LS_IF_NONPOS;
                    if (!(k1r && k2c))
                    begin
                        ctrl.fault = FAULT_ILLEGAL;
                    end
                    else if (opf1 != FAULT_OK)
                    begin
                        ctrl.fault = opf1;
                    end
                    else
                    begin
                        ctrl.fault = tgt_ok2 ? FAULT_OK : FAULT_BAD_TARGET;
                    end
                end
            end
            OP_HLT:
            begin
                ctrl.line_sel = LS_HOLD;
                ctrl.halt     = 1'b1;
            end
            default:
            begin
                ctrl.line_sel = LS_HOLD;
                ctrl.fault    = FAULT_UNKNOWN;
            end
        endcase
    end

endmodule

>>> design/tiny_register_machine_execute.sv
// Flow: operands are read into the execute stage registers when the input beat is accepted,
//   and execute loads the output register when the stage advances into a free output register.
// Throughput: one instruction per cycle while m_tready does not stall the output; the
//   register file takes one write and two reads per cycle, the data memory one write and
//   one read, and a read that hits the word being written in the same cycle is forwarded.
// Reset: rst_n clears the line counter, halt flag, pipeline valids and per-word valid
//   bits; a word not yet written reads as zero, so no clearing pass is needed.
`include "assert_macros.svh"

module tiny_register_machine_execute
    import trm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: operation[2:0], first_value[33:3], second_value[64:34], zero pad
    input  logic [71:0] s_tdata,
    // s_tuser: first_kind[1:0], second_kind[3:2]
    input  logic [3:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: next_line[7:0], print_value[39:8], halted[40], fault[43:41], zero pad
    output logic [47:0] m_tdata,
    // m_tuser: print_valid[0], print_signed[1]
    output logic [1:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready
);

    // ------------------------------------------------------------------
    // Input beat unpack and read address generation
    // ------------------------------------------------------------------
    insn_t             in_insn;
    logic              s_accept;
    logic [REG_AW-1:0] ra_a, ra_b;
    logic [MEM_AW-1:0] ra_m;

    always_comb
    begin
        in_insn.op           = s_tdata[2:0];
        in_insn.first_value  = s_tdata[33:3];
        in_insn.second_value = s_tdata[64:34];
        in_insn.first_kind   = s_tuser[1:0];
        in_insn.second_kind  = s_tuser[3:2];
        s_accept = s_tvalid && s_tready;
        // register numbers count from one
        ra_a = REG_AW'(in_insn.first_value - VAL_W'(1));
        ra_b = REG_AW'(in_insn.second_value - VAL_W'(1));
        ra_m = (in_insn.first_kind == KIND_MEM) ? MEM_AW'(in_insn.first_value)
                                                : MEM_AW'(in_insn.second_value);
    end

    // ------------------------------------------------------------------
    // Execute stage registers and architectural state
    // ------------------------------------------------------------------
    logic                 s1_valid_reg, s1_valid_next;
    insn_t                s1_insn_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [47:0]          out_tdata_reg;
    logic [1:0]           out_tuser_reg;
    logic [LINE_W-1:0]    line_reg, line_next;
    logic                 halt_reg, halt_next;
    logic [NUM_REGS-1:0]  reg_valid_reg, reg_valid_next;
    logic [MEM_WORDS-1:0] mem_valid_reg, mem_valid_next;

    // read-side bypass, captured with each read
    logic              fwd_a_reg, fwd_b_reg, fwd_m_reg;
    logic [DATA_W-1:0] fwd_rdata_reg, fwd_mdata_reg;
    logic              va_reg, vb_reg, vm_reg;

    logic              s1_fire;
    ctrl_t             ctrl;
    logic              active;
    logic              reg_we, mem_we;
    logic [REG_AW-1:0] reg_waddr;
    logic [MEM_AW-1:0] mem_waddr;
    logic [DATA_W-1:0] reg_wdata, mem_wdata;
    logic [DATA_W-1:0] rf_a_rdata, rf_b_rdata, dm_rdata;
    logic [DATA_W-1:0] rega, regb, memv, val1, val2, const2;
    logic [LINE_W-1:0] line_adv, line_tgt1, line_tgt2, line_result;
    logic              o_print;
    logic [DATA_W-1:0] o_value;
    logic              o_halted;
    logic [2:0]        o_fault;

    trm_decode u_decode (
        .insn (s1_insn_reg),
        .ctrl (ctrl)
    );

    // ------------------------------------------------------------------
    // Storage: two read copies of the register file, one data memory
    // ------------------------------------------------------------------
    trm_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_rf_a (
        .clk   (clk),
        .we    (reg_we),
        .waddr (reg_waddr),
        .wdata (reg_wdata),
        .re    (s_accept),
        .raddr (ra_a),
        .rdata (rf_a_rdata)
    );

    trm_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_rf_b (
        .clk   (clk),
        .we    (reg_we),
        .waddr (reg_waddr),
        .wdata (reg_wdata),
        .re    (s_accept),
        .raddr (ra_b),
        .rdata (rf_b_rdata)
    );

    trm_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_dm (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (s_accept),
        .raddr (ra_m),
        .rdata (dm_rdata)
    );

    // ------------------------------------------------------------------
    // Handshake: execute stage advances when the output register frees up
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_fire  = s1_valid_reg && (!out_valid_reg || m_tready);
        s_tready = !s1_valid_reg || s1_fire;
        m_tvalid = out_valid_reg;
        m_tdata  = out_tdata_reg;
        m_tuser  = out_tuser_reg;
    end

    // ------------------------------------------------------------------
    // Execute: operand select, write-back, line counter, result beat
    // ------------------------------------------------------------------
    always_comb
    begin
        // bypass wins, then unwritten words read as zero
        rega   = fwd_a_reg ? fwd_rdata_reg : (va_reg ? rf_a_rdata : '0);
        regb   = fwd_b_reg ? fwd_rdata_reg : (vb_reg ? rf_b_rdata : '0);
        memv   = fwd_m_reg ? fwd_mdata_reg : (vm_reg ? dm_rdata : '0);
        const2 = {1'b0, s1_insn_reg.second_value};

        case (s1_insn_reg.first_kind)
            KIND_REG: val1 = rega;
            KIND_MEM: val1 = memv;
            default:  val1 = {1'b0, s1_insn_reg.first_value};
        endcase
        case (s1_insn_reg.second_kind)
            KIND_REG: val2 = regb;
            KIND_MEM: val2 = memv;
            default:  val2 = const2;
        endcase

        active = !halt_reg && (ctrl.fault == FAULT_OK);

        // write-back happens only when the beat leaves the stage
        reg_we    = s1_fire && active && ctrl.reg_we;
        reg_waddr = ctrl.reg_dst_first ? REG_AW'(s1_insn_reg.first_value - VAL_W'(1))
                                       : REG_AW'(s1_insn_reg.second_value - VAL_W'(1));
        case (ctrl.reg_src)
            RS_VAL1:   reg_wdata = val1;
            RS_CONST2: reg_wdata = const2;
            RS_ADD:    reg_wdata = rega + val2;
            RS_SUB:    reg_wdata = rega - val2;
            default:   reg_wdata = val1;
        endcase

        mem_we    = s1_fire && active && ctrl.mem_we;
        mem_waddr = ctrl.mem_dst_first ? MEM_AW'(s1_insn_reg.first_value)
                                       : MEM_AW'(s1_insn_reg.second_value);
        mem_wdata = ctrl.mem_src_const ? const2 : val1;

        // line counter wraps past the last line
        line_adv  = (line_reg == LINE_W'(MAX_LINES - 1)) ? '0 : line_reg + LINE_W'(1);
        line_tgt1 = LINE_W'(s1_insn_reg.first_value - VAL_W'(1));
        line_tgt2 = LINE_W'(s1_insn_reg.second_value - VAL_W'(1));
        if (!active)
        begin
            line_result = line_reg;
        end
        else
        begin
            case (ctrl.line_sel)
                LS_ADV:        line_result = line_adv;
                LS_JUMP_FIRST: line_result = line_tgt1;
                LS_IF_ZERO:    line_result = (rega == '0) ? line_tgt2 : line_adv;
                LS_IF_NONPOS:  line_result = ((rega == '0) || rega[DATA_W-1]) ? line_tgt2
                                                                             : line_adv;
                default:       line_result = line_reg;
            endcase
        end

        // halted machine reports no fault and ignores the beat
        o_print  = active && ctrl.print;
        o_value  = o_print ? val1 : '0;
        o_halted = halt_reg || ctrl.halt;
        o_fault  = halt_reg ? FAULT_OK : ctrl.fault;
    end

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_valid_next  = s_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_fire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        line_next      = s1_fire ? line_result : line_reg;
        halt_next      = halt_reg || (s1_fire && ctrl.halt);

        reg_valid_next = reg_valid_reg;
        if (reg_we)
        begin
            reg_valid_next[reg_waddr] = 1'b1;
        end
        mem_valid_next = mem_valid_reg;
        if (mem_we)
        begin
            mem_valid_next[mem_waddr] = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            line_reg      <= '0;
            halt_reg      <= 1'b0;
            reg_valid_reg <= '0;
            mem_valid_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            line_reg      <= line_next;
            halt_reg      <= halt_next;
            reg_valid_reg <= reg_valid_next;
            mem_valid_reg <= mem_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_insn_reg   <= in_insn;
            // sample valid bits and bypass the word written at this same edge
            va_reg        <= reg_valid_reg[ra_a];
            vb_reg        <= reg_valid_reg[ra_b];
            vm_reg        <= mem_valid_reg[ra_m];
            fwd_a_reg     <= reg_we && (reg_waddr == ra_a);
            fwd_b_reg     <= reg_we && (reg_waddr == ra_b);
            fwd_m_reg     <= mem_we && (mem_waddr == ra_m);
            fwd_rdata_reg <= reg_wdata;
            fwd_mdata_reg <= mem_wdata;
        end
        if (s1_fire)
        begin
            out_tdata_reg <= {4'd0, o_fault, o_halted, o_value, 8'(line_result)};
            out_tuser_reg <= {o_print && (s1_insn_reg.first_kind == KIND_REG), o_print};
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_NEXT(a_halt_sticky, clk, rst_n, halt_reg, halt_reg)
    `ASSERT_NEVER(a_one_store_write, clk, rst_n, reg_we && mem_we)
    `ASSERT_IMPLIES(a_halted_no_write, clk, rst_n, halt_reg, !reg_we && !mem_we)
    `ASSERT_IMPLIES(a_fault_no_print, clk, rst_n, m_tvalid && (m_tdata[43:41] != 0), !m_tuser[0])
    `ASSERT_NEXT(a_stall_holds_line, clk, rst_n, s1_valid_reg && !s1_fire, $stable(line_reg))

endmodule
